// ===== rtl/core/chs_pkg.sv =====
// Package for the chained hash set: shared types, codes and constants.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package chs_pkg;

  // Default geometry handed down from the top-level parameters.
  localparam int DEF_NUM_BUCKETS  = 8;
  localparam int DEF_BUCKET_DEPTH = 4;

  // Key width is fixed by the request field.
  localparam int KEY_WIDTH = 31;

  // Configuration register.
  localparam int              CFG_W              = 4;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 4'd7;

  // Width of the reported bucket number.
  localparam int IDX_OUT_W = 3;

  // Division step counter.
  localparam int DIV_CW = $clog2(KEY_WIDTH);

  // Operation codes; code 3 is unused and leaves the store untouched.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_ERASE  = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [KEY_WIDTH-1:0] item_key;
  } req_t;

  typedef struct packed {
    logic                 present;
    logic                 bucket_full;
    logic [IDX_OUT_W-1:0] bucket_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/chs_ctrl.sv =====
// Controller of the chained hash set: sequences divide, bucket scan and commit.
// Depends on chs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  chs_pkg::stat_t stat,
  output chs_pkg::cmd_t  cmd
);
  import chs_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The result register must be free before the store is updated.
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/chs_dp.sv =====
// Datapath of the chained hash set: divider, slot key memory, valid bits,
// scan trackers and result register. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_dp #(
  parameter int NUM_BUCKETS  = chs_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = chs_pkg::DEF_BUCKET_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [chs_pkg::CFG_W-1:0] cfg_data,
  input  chs_pkg::req_t            in_data,
  output chs_pkg::rsp_t            out_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  chs_pkg::cmd_t            cmd,
  output chs_pkg::stat_t           stat
);
  import chs_pkg::*;

  localparam int TOTAL   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int SLOT_AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int IDXW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNTW    = $clog2(BUCKET_DEPTH + 1);

  // Configuration and latched request.
  logic [CFG_W-1:0]     bucket_count;
  logic [CFG_W-1:0]     divisor;
  logic [CFG_W-1:0]     div_eff;
  logic [1:0]           func;
  logic [KEY_WIDTH-1:0] key;

  // Divider.
  logic [KEY_WIDTH-1:0] key_sh;
  logic [CFG_W-1:0]     rem;
  logic [DIV_CW-1:0]    div_cnt;
  logic [CFG_W:0]       trial;

  // Scan.
  logic [CNTW-1:0]      scan_cnt;
  logic                 rd_pend;
  logic [IDXW-1:0]      rd_idx;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 free_found;
  logic [IDXW-1:0]      free_idx;
  logic                 match_found;
  logic [IDXW-1:0]      match_idx;
  logic [SLOT_AW-1:0]   slot_base;
  logic [SLOT_AW-1:0]   rd_addr;
  logic [SLOT_AW-1:0]   cmp_addr;
  logic                 cmp_valid;

  // Store.
  logic [KEY_WIDTH-1:0] slot_key [TOTAL];
  logic [TOTAL-1:0]     slot_valid;
  logic                 mem_we;

  always_comb begin
    div_eff = bucket_count;
    if (bucket_count == '0) begin
      div_eff = CFG_W'(1);
    end else if (32'(bucket_count) > NUM_BUCKETS) begin
      div_eff = CFG_W'(NUM_BUCKETS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  // Restoring division, one key bit per cycle, MSB first.
  assign trial = {rem, key_sh[KEY_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func    <= in_data.func;
      key     <= in_data.item_key;
      key_sh  <= in_data.item_key;
      divisor <= div_eff;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      key_sh  <= key_sh << 1;
      div_cnt <= div_cnt + DIV_CW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= CFG_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[CFG_W-1:0];
      end
    end
  end

  assign slot_base = SLOT_AW'(32'(rem) * BUCKET_DEPTH);
  assign rd_addr   = slot_base + SLOT_AW'(scan_cnt[IDXW-1:0]);
  assign cmp_addr  = slot_base + SLOT_AW'(rd_idx);
  assign cmp_valid = slot_valid[cmp_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend     <= 1'b0;
      scan_cnt    <= '0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else if (cmd.load) begin
      rd_pend     <= 1'b0;
      scan_cnt    <= '0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
    end else if (cmd.scan_step) begin
      rd_pend <= (scan_cnt < CNTW'(BUCKET_DEPTH));
      if (scan_cnt < CNTW'(BUCKET_DEPTH)) begin
        scan_cnt <= scan_cnt + CNTW'(1);
      end
      if (rd_pend) begin
        if (!cmp_valid && !free_found) begin
          free_found <= 1'b1;
        end
        if (cmp_valid && rd_data == key && !match_found) begin
          match_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_idx <= scan_cnt[IDXW-1:0];
      if (rd_pend) begin
        if (!cmp_valid && !free_found) begin
          free_idx <= rd_idx;
        end
        if (cmp_valid && rd_data == key && !match_found) begin
          match_idx <= rd_idx;
        end
      end
    end
  end

  // Slot key memory: one write port, one registered read port.
  assign mem_we = cmd.commit && func == FUNC_INSERT && free_found;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_key[slot_base + SLOT_AW'(free_idx)] <= key;
    end
    rd_data <= slot_key[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit) begin
      if (func == FUNC_INSERT && free_found) begin
        slot_valid[slot_base + SLOT_AW'(free_idx)] <= 1'b1;
      end else if (func == FUNC_ERASE && match_found) begin
        slot_valid[slot_base + SLOT_AW'(match_idx)] <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.present      <= (func == FUNC_FIND || func == FUNC_ERASE) && match_found;
      out_data.bucket_full  <= (func == FUNC_INSERT) && !free_found;
      out_data.bucket_index <= rem[IDX_OUT_W-1:0];
    end
  end

  assign stat.div_last  = (div_cnt == DIV_CW'(KEY_WIDTH - 1));
  assign stat.scan_last = (scan_cnt == CNTW'(BUCKET_DEPTH));
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/core/chained_hash_set.sv =====
// Chained hash set top level over chs_pkg, chs_ctrl and chs_dp: keys bucketed by key modulo
// bucket_count, with 0 taken as 1 and values above NUM_BUCKETS as NUM_BUCKETS. Between one
// accept and the next a request passes through the bit-serial modulo, the bucket scan through
// the single read port of the slot key memory, the commit, and a return to idle for the accept.
// The commit loads the result register and waits while the previous result is unaccepted.
// Reset clears all valid bits, bucket_count = 7.
`timescale 1ns / 1ps

module chained_hash_set #(
  parameter int NUM_BUCKETS  = chs_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = chs_pkg::DEF_BUCKET_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration: bucket_count, written whenever cfg_we is high.
  input  logic                     cfg_we,
  input  logic [chs_pkg::CFG_W-1:0] cfg_data,
  // Request channel.
  input  logic                     in_valid,
  output logic                     in_ready,
  input  chs_pkg::req_t            in_data,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output chs_pkg::rsp_t            out_data
);
  import chs_pkg::*;

  // The controller walks each request through three phases: the restoring
  // divider produces the bucket number, the scan reads every slot of the
  // bucket while tracking the lowest free slot and the lowest matching slot,
  // and the commit updates the store and loads the result register.
  // The result register decouples the two sides: a new request is taken as
  // soon as the commit is done, even if the previous result is still waiting.
  cmd_t  cmd;
  stat_t stat;

  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the configuration register, the divider, the slot key
  // memory with its valid bits and the result register.
  chs_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
